// File: rtl/core/robs_pkg.sv
// robs_pkg: widths, codes and shared types of the ray / oriented box slab test core
// no dependencies; compiled first

package robs_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int NAXIS      = 3;

	localparam int IN_W       = 32;
	localparam int HALF_W     = 31;
	localparam int TRIG_W     = 18;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam int DIFF_W     = IN_W + 1;
	localparam int PROD_W     = DIFF_W + TRIG_W;
	localparam int DPROD_W    = IN_W + TRIG_W;
	localparam int LO_W       = PROD_W + 1 - FRAC_BITS;
	localparam int LD_W       = DPROD_W + 1 - FRAC_BITS;
	localparam int NUM_W      = LO_W + 1;
	localparam int T_W        = 32;
	localparam int DIV_LAT    = T_W + 2;

	localparam int SUM_W      = 2 * TRIG_W;
	localparam int ROOT_W     = TRIG_W;
	localparam int SQ_REM_W   = ROOT_W + 3;
	localparam int NQ_W       = TRIG_W + FRAC_BITS;
	localparam int NU_CNT_W   = $clog2(NQ_W);

	localparam logic signed [T_W-1:0]    T_MAX    = {1'b0, {(T_W-1){1'b1}}};
	localparam logic signed [T_W-1:0]    T_MIN    = {1'b1, {(T_W-1){1'b0}}};
	localparam logic signed [TRIG_W-1:0] NORM_ONE = TRIG_W'(ONE);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = CFG_IDX_W'(0),
		REG_CENTER_Y = CFG_IDX_W'(1),
		REG_CENTER_Z = CFG_IDX_W'(2),
		REG_HALF_X   = CFG_IDX_W'(3),
		REG_HALF_Y   = CFG_IDX_W'(4),
		REG_HALF_Z   = CFG_IDX_W'(5),
		REG_COS_YAW  = CFG_IDX_W'(6),
		REG_SIN_YAW  = CFG_IDX_W'(7)
	} cfg_idx_t;

	typedef enum logic [1:0] {AX_NONE, AX_X, AX_Y, AX_Z} axis_t;

	typedef enum logic [1:0] {NU_IDLE, NU_SQUARE, NU_ROOT, NU_DIVIDE} nu_state_t;

	typedef struct packed {
		logic              v;
		logic [NAXIS-1:0]  zero;
		logic              pmiss;
		logic [HALF_W-1:0] maxd;
	} side_t;

	typedef struct packed {
		logic                     busy;
		logic signed [TRIG_W-1:0] ncos;
		logic signed [TRIG_W-1:0] nsin;
	} norm_t;

endpackage

// File: rtl/core/robs_if.sv
// robs_if: ray, result and config write channels of the slab test core
// depends on robs_pkg

interface robs_ray_if import robs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] origin_x;
	logic signed [IN_W-1:0] origin_y;
	logic signed [IN_W-1:0] origin_z;
	logic signed [IN_W-1:0] dir_x;
	logic signed [IN_W-1:0] dir_y;
	logic signed [IN_W-1:0] dir_z;
	logic [HALF_W-1:0]      max_dist;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		max_dist, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		max_dist, output ready);
endinterface

interface robs_res_if import robs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic [HALF_W-1:0]        t_hit;
	logic signed [TRIG_W-1:0] normal_x;
	logic signed [TRIG_W-1:0] normal_y;
	logic signed [TRIG_W-1:0] normal_z;

	modport source (output valid, hit, t_hit, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, hit, t_hit, normal_x, normal_y, normal_z, output ready);
endinterface

interface robs_cfg_if import robs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ray_oriented_box_slab_test_core.sv
// ray_oriented_box_slab_test_core: ray against yaw-rotated box, slab test, Q16.16
// depends on robs_pkg, robs_if, robs_div, robs_norm
//
//   channel  dir  handshake      word
//   ray      in   valid/ready    origin xyz, dir xyz, max_dist
//   res      out  valid/ready    hit, t_hit, normal xyz
//   cfg      in   valid/ready    index, data (ready always high)
//
// one ray per cycle unless stalled; 4 transform stages, 34 divider stages, 3 finish stages
// the six slab divides run in pipelined dividers, one quotient bit per stage
// a full output word not taken holds the whole pipeline; nothing is lost or repeated
// after a write of cos_yaw or sin_yaw, ray ready stays low while the normal scale is rebuilt
// reset: box at origin, unit half extents, zero yaw

module ray_oriented_box_slab_test_core import robs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	robs_ray_if.sink  ray,
	robs_res_if.source res,
	robs_cfg_if.sink  cfg
);

	logic signed [IN_W-1:0]   center_q [NAXIS];
	logic [HALF_W-1:0]        half_q [NAXIS];
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic                     cfg_wr, nu_start;
	norm_t                    norm;

	logic en, accept;

	logic                      v_s1, v_s2, v_s3, v_s5, v_s6, v_s7;
	logic signed [DIFF_W-1:0]  dp_s1 [NAXIS];
	logic signed [IN_W-1:0]    dir_s1 [NAXIS];
	logic [HALF_W-1:0]         maxd_s1, maxd_s2, maxd_s3;

	logic signed [PROD_W-1:0]  p_xc_s2, p_zs_s2, p_xs_s2, p_zc_s2;
	logic signed [DPROD_W-1:0] q_xc_s2, q_zs_s2, q_xs_s2, q_zc_s2;
	logic signed [DIFF_W-1:0]  dy_s2;
	logic signed [IN_W-1:0]    vy_s2;
	logic signed [PROD_W:0]    lx_sum, lz_sum;
	logic signed [DPROD_W:0]   ldx_sum, ldz_sum;

	logic signed [LO_W-1:0]    lo_s3 [NAXIS];
	logic signed [LD_W-1:0]    ld_s3 [NAXIS];

	logic signed [NUM_W-1:0]   hb_e [NAXIS];
	logic signed [NUM_W-1:0]   lo_e [NAXIS];
	logic signed [NUM_W-1:0]   dlo_c [NAXIS];
	logic signed [NUM_W-1:0]   dhi_c [NAXIS];
	logic [NAXIS-1:0]          zero_c, pm_c;

	logic signed [NUM_W-1:0]   dlo_s4 [NAXIS];
	logic signed [NUM_W-1:0]   dhi_s4 [NAXIS];
	logic signed [LD_W-1:0]    ld_s4 [NAXIS];
	side_t                     side_s4;
	side_t                     side_d [DIV_LAT];

	logic signed [T_W-1:0]     t1 [NAXIS];
	logic signed [T_W-1:0]     t2 [NAXIS];
	logic signed [T_W-1:0]     near_s5 [NAXIS];
	logic signed [T_W-1:0]     far_s5 [NAXIS];
	logic [NAXIS-1:0]          swap_s5, zero_s5;
	logic                      pmiss_s5;
	logic [HALF_W-1:0]         maxd_s5;

	logic signed [T_W-1:0]     tmin_c, tmax_c;
	axis_t                     axis_c;
	logic                      sgp_c;
	logic signed [T_W-1:0]     tmin_s6, tmax_s6;
	axis_t                     axis_s6;
	logic                      sgp_s6, pmiss_s6;

	logic                      hit_c;
	logic signed [TRIG_W-1:0]  nx_c, ny_c, nz_c;
	logic                      hit_s7;
	logic [HALF_W-1:0]         t_hit_s7;
	logic signed [TRIG_W-1:0]  nx_s7, ny_s7, nz_s7;

	// config registers
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign nu_start  = cfg_wr && (cfg.index == REG_COS_YAW || cfg.index == REG_SIN_YAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NAXIS; a++) begin
				center_q[a] <= '0;
				half_q[a]   <= HALF_W'(ONE);
			end
			cos_q <= NORM_ONE;
			sin_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_CENTER_X: center_q[0] <= cfg.data;
				REG_CENTER_Y: center_q[1] <= cfg.data;
				REG_CENTER_Z: center_q[2] <= cfg.data;
				REG_HALF_X:   half_q[0]   <= cfg.data[HALF_W-1:0];
				REG_HALF_Y:   half_q[1]   <= cfg.data[HALF_W-1:0];
				REG_HALF_Z:   half_q[2]   <= cfg.data[HALF_W-1:0];
				REG_COS_YAW:  cos_q       <= cfg.data[TRIG_W-1:0];
				REG_SIN_YAW:  sin_q       <= cfg.data[TRIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	robs_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nu_start),
		.cos_in (cos_q),
		.sin_in (sin_q),
		.norm   (norm)
	);

	// flow control
	assign en        = !v_s7 || res.ready;
	assign ray.ready = en && !norm.busy;
	assign accept    = ray.valid && ray.ready;

	// rotation into box space
	always_comb begin
		lx_sum  = (PROD_W+1)'(p_xc_s2) - (PROD_W+1)'(p_zs_s2);
		lz_sum  = (PROD_W+1)'(p_xs_s2) + (PROD_W+1)'(p_zc_s2);
		ldx_sum = (DPROD_W+1)'(q_xc_s2) - (DPROD_W+1)'(q_zs_s2);
		ldz_sum = (DPROD_W+1)'(q_xs_s2) + (DPROD_W+1)'(q_zc_s2);
	end

	// slab numerators and parallel check
	always_comb begin
		for (int a = 0; a < NAXIS; a++) begin
			hb_e[a]   = NUM_W'($signed({1'b0, half_q[a]}));
			lo_e[a]   = NUM_W'(lo_s3[a]);
			dlo_c[a]  = -hb_e[a] - lo_e[a];
			dhi_c[a]  = hb_e[a] - lo_e[a];
			zero_c[a] = ld_s3[a] == '0;
			pm_c[a]   = zero_c[a] && (dhi_c[a][NUM_W-1] ||
				(!dlo_c[a][NUM_W-1] && dlo_c[a] != '0));
		end
	end

	for (genvar a = 0; a < NAXIS; a++) begin : g_div
		robs_div u_div_lo (
			.clk (clk),
			.en  (en),
			.num (dlo_s4[a]),
			.den (ld_s4[a]),
			.quo (t1[a])
		);
		robs_div u_div_hi (
			.clk (clk),
			.en  (en),
			.num (dhi_s4[a]),
			.den (ld_s4[a]),
			.quo (t2[a])
		);
	end

	// interval accumulation over x, y, z
	always_comb begin
		tmin_c = '0;
		tmax_c = $signed({1'b0, maxd_s5});
		axis_c = AX_NONE;
		sgp_c  = 1'b0;
		for (int a = 0; a < NAXIS; a++) begin
			if (!zero_s5[a]) begin
				if (near_s5[a] > tmin_c) begin
					tmin_c = near_s5[a];
					axis_c = (a == 0) ? AX_X : ((a == 1) ? AX_Y : AX_Z);
					sgp_c  = swap_s5[a];
				end
				if (far_s5[a] < tmax_c) begin
					tmax_c = far_s5[a];
				end
			end
		end
	end

	// hit decision and world normal
	always_comb begin
		hit_c = !pmiss_s6 && axis_s6 != AX_NONE && !(tmin_s6 > tmax_s6);
		nx_c  = '0;
		ny_c  = '0;
		nz_c  = '0;
		if (hit_c) begin
			unique case (axis_s6)
				AX_X: begin
					nx_c = sgp_s6 ? norm.ncos : -norm.ncos;
					nz_c = sgp_s6 ? -norm.nsin : norm.nsin;
				end
				AX_Y: begin
					ny_c = sgp_s6 ? NORM_ONE : -NORM_ONE;
				end
				AX_Z: begin
					nx_c = sgp_s6 ? norm.nsin : -norm.nsin;
					nz_c = sgp_s6 ? norm.ncos : -norm.ncos;
				end
				AX_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// valid bits and side fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			side_s4 <= '0;
			for (int k = 0; k < DIV_LAT; k++) begin
				side_d[k] <= '0;
			end
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
		end else if (en) begin
			v_s1          <= accept;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			side_s4.v     <= v_s3;
			side_s4.zero  <= zero_c;
			side_s4.pmiss <= |pm_c;
			side_s4.maxd  <= maxd_s3;
			side_d[0]     <= side_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
			v_s5 <= side_d[DIV_LAT-1].v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			dp_s1[0]  <= DIFF_W'(ray.origin_x) - DIFF_W'(center_q[0]);
			dp_s1[1]  <= DIFF_W'(ray.origin_y) - DIFF_W'(center_q[1]);
			dp_s1[2]  <= DIFF_W'(ray.origin_z) - DIFF_W'(center_q[2]);
			dir_s1[0] <= ray.dir_x;
			dir_s1[1] <= ray.dir_y;
			dir_s1[2] <= ray.dir_z;
			maxd_s1   <= ray.max_dist;

			p_xc_s2 <= PROD_W'(dp_s1[0]) * PROD_W'(cos_q);
			p_zs_s2 <= PROD_W'(dp_s1[2]) * PROD_W'(sin_q);
			p_xs_s2 <= PROD_W'(dp_s1[0]) * PROD_W'(sin_q);
			p_zc_s2 <= PROD_W'(dp_s1[2]) * PROD_W'(cos_q);
			q_xc_s2 <= DPROD_W'(dir_s1[0]) * DPROD_W'(cos_q);
			q_zs_s2 <= DPROD_W'(dir_s1[2]) * DPROD_W'(sin_q);
			q_xs_s2 <= DPROD_W'(dir_s1[0]) * DPROD_W'(sin_q);
			q_zc_s2 <= DPROD_W'(dir_s1[2]) * DPROD_W'(cos_q);
			dy_s2   <= dp_s1[1];
			vy_s2   <= dir_s1[1];
			maxd_s2 <= maxd_s1;

			lo_s3[0] <= lx_sum[PROD_W:FRAC_BITS];
			lo_s3[1] <= LO_W'(dy_s2);
			lo_s3[2] <= lz_sum[PROD_W:FRAC_BITS];
			ld_s3[0] <= ldx_sum[DPROD_W:FRAC_BITS];
			ld_s3[1] <= LD_W'(vy_s2);
			ld_s3[2] <= ldz_sum[DPROD_W:FRAC_BITS];
			maxd_s3  <= maxd_s2;

			for (int a = 0; a < NAXIS; a++) begin
				dlo_s4[a]  <= dlo_c[a];
				dhi_s4[a]  <= dhi_c[a];
				ld_s4[a]   <= ld_s3[a];
				swap_s5[a] <= t1[a] > t2[a];
				near_s5[a] <= (t1[a] > t2[a]) ? t2[a] : t1[a];
				far_s5[a]  <= (t1[a] > t2[a]) ? t1[a] : t2[a];
			end
			zero_s5  <= side_d[DIV_LAT-1].zero;
			pmiss_s5 <= side_d[DIV_LAT-1].pmiss;
			maxd_s5  <= side_d[DIV_LAT-1].maxd;

			tmin_s6  <= tmin_c;
			tmax_s6  <= tmax_c;
			axis_s6  <= axis_c;
			sgp_s6   <= sgp_c;
			pmiss_s6 <= pmiss_s5;

			hit_s7   <= hit_c;
			t_hit_s7 <= hit_c ? tmin_s6[HALF_W-1:0] : '0;
			nx_s7    <= nx_c;
			ny_s7    <= ny_c;
			nz_s7    <= nz_c;
		end
	end

	assign res.valid    = v_s7;
	assign res.hit      = hit_s7;
	assign res.t_hit    = t_hit_s7;
	assign res.normal_x = nx_s7;
	assign res.normal_y = ny_s7;
	assign res.normal_z = nz_s7;

endmodule

// File: rtl/core/robs_div.sv
// robs_div: pipelined signed divider, one quotient bit per stage, saturating to 32 bits
// depends on robs_pkg; numerator is scaled by 2^FRAC_BITS inside

module robs_div import robs_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [LD_W-1:0]  den,
	output logic signed [T_W-1:0]   quo
);

	localparam int NM_W = NUM_W;
	localparam int DM_W = LD_W;
	localparam int N_W  = NM_W + FRAC_BITS;

	logic [NM_W-1:0] nmag;
	logic [DM_W-1:0] dmag;
	logic [N_W-1:0]  nfull;
	logic [DM_W-1:0] nhi;

	logic [DM_W-1:0] rem_s [T_W];
	logic [T_W-1:0]  low_s [T_W];
	logic [DM_W-1:0] d_s   [T_W];
	logic [T_W-1:0]  q_s   [T_W+1];
	logic            neg_s [T_W+1];
	logic            ovf_s [T_W+1];

	logic [DM_W:0]   tr [T_W];
	logic [DM_W:0]   df [T_W];
	logic            ge [T_W];

	logic [T_W-1:0]        qf;
	logic signed [T_W-1:0] quo_c;

	always_comb begin
		nmag  = num[NM_W-1] ? NM_W'(-num) : NM_W'(num);
		dmag  = den[DM_W-1] ? DM_W'(-den) : DM_W'(den);
		nfull = {nmag, {FRAC_BITS{1'b0}}};
		nhi   = DM_W'(nfull[N_W-1:T_W]);
	end

	always_comb begin
		for (int k = 0; k < T_W; k++) begin
			tr[k] = {rem_s[k], low_s[k][T_W-1]};
			df[k] = tr[k] - {1'b0, d_s[k]};
			ge[k] = tr[k] >= {1'b0, d_s[k]};
		end
	end

	always_comb begin
		qf = q_s[T_W];
		if (!neg_s[T_W]) begin
			quo_c = (ovf_s[T_W] || qf[T_W-1]) ? T_MAX : $signed(qf);
		end else begin
			quo_c = (ovf_s[T_W] || qf > {1'b1, {(T_W-1){1'b0}}}) ? T_MIN : -$signed(qf);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= nhi;
			low_s[0] <= nfull[T_W-1:0];
			d_s[0]   <= dmag;
			q_s[0]   <= '0;
			neg_s[0] <= num[NM_W-1] ^ den[DM_W-1];
			ovf_s[0] <= nhi >= dmag;
			for (int k = 0; k < T_W; k++) begin
				if (k < T_W - 1) begin
					rem_s[k+1] <= ge[k] ? df[k][DM_W-1:0] : tr[k][DM_W-1:0];
					low_s[k+1] <= low_s[k] << 1;
					d_s[k+1]   <= d_s[k];
				end
				q_s[k+1]   <= {q_s[k][T_W-2:0], ge[k]};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
			quo <= quo_c;
		end
	end

endmodule

// File: rtl/core/robs_norm.sv
// robs_norm: face normal scale for the yaw pair, cos and sin over isqrt(cos^2 + sin^2)
// depends on robs_pkg; sequential, reruns after each write of the yaw pair

module robs_norm import robs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [TRIG_W-1:0] cos_in,
	input  logic signed [TRIG_W-1:0] sin_in,
	output norm_t                    norm
);

	nu_state_t state_q, state_d;

	logic [NU_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_REM_W-1:0] rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W-1:0]   len_q;
	logic [NQ_W-1:0]     num_c_q, num_s_q, quo_c_q, quo_s_q;
	logic [ROOT_W-1:0]   rem_c_q, rem_s_q;
	logic                neg_c_q, neg_s_q;

	logic [SQ_REM_W-1:0] rr, trial, rem_n;
	logic [ROOT_W-1:0]   root_n;
	logic                ge_r;
	logic [ROOT_W:0]     tc, ts, dc, ds;
	logic                ge_c, ge_s;
	logic [TRIG_W-1:0]   abs_c, abs_s;
	logic [TRIG_W-1:0]   mag_c, mag_s;

	always_comb begin
		rr     = {rem_q[SQ_REM_W-3:0], sum_q[SUM_W-1 -: 2]};
		trial  = SQ_REM_W'({root_q, 2'b01});
		ge_r   = rr >= trial;
		rem_n  = ge_r ? rr - trial : rr;
		root_n = {root_q[ROOT_W-2:0], ge_r};
		tc     = {rem_c_q, num_c_q[NQ_W-1]};
		ts     = {rem_s_q, num_s_q[NQ_W-1]};
		dc     = tc - {1'b0, len_q};
		ds     = ts - {1'b0, len_q};
		ge_c   = tc >= {1'b0, len_q};
		ge_s   = ts >= {1'b0, len_q};
		abs_c  = cos_in[TRIG_W-1] ? TRIG_W'(-cos_in) : TRIG_W'(cos_in);
		abs_s  = sin_in[TRIG_W-1] ? TRIG_W'(-sin_in) : TRIG_W'(sin_in);
	end

	// next state
	always_comb begin
		state_d = state_q;
		priority if (start) begin
			state_d = NU_SQUARE;
		end else begin
			unique case (state_q)
				NU_IDLE:   state_d = NU_IDLE;
				NU_SQUARE: state_d = NU_ROOT;
				NU_ROOT:   state_d = (cnt_q == '0) ? NU_DIVIDE : NU_ROOT;
				NU_DIVIDE: state_d = (cnt_q == '0) ? NU_IDLE : NU_DIVIDE;
				default:   state_d = NU_IDLE;
			endcase
		end
	end

	// outputs
	always_comb begin
		mag_c = (quo_c_q > NQ_W'(ONE)) ? TRIG_W'(ONE) : quo_c_q[TRIG_W-1:0];
		mag_s = (quo_s_q > NQ_W'(ONE)) ? TRIG_W'(ONE) : quo_s_q[TRIG_W-1:0];
		norm.busy = state_q != NU_IDLE;
		if (len_q == '0) begin
			norm.ncos = '0;
			norm.nsin = '0;
		end else begin
			norm.ncos = neg_c_q ? -$signed(mag_c) : $signed(mag_c);
			norm.nsin = neg_s_q ? -$signed(mag_s) : $signed(mag_s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NU_IDLE;
			len_q   <= ROOT_W'(ONE);
			quo_c_q <= NQ_W'(ONE);
			quo_s_q <= '0;
			neg_c_q <= 1'b0;
			neg_s_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				NU_IDLE: begin
				end
				NU_SQUARE: begin
					sum_q  <= SUM_W'(cos_in * cos_in) + SUM_W'(sin_in * sin_in);
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= NU_CNT_W'(ROOT_W - 1);
				end
				NU_ROOT: begin
					sum_q  <= sum_q << 2;
					rem_q  <= rem_n;
					root_q <= root_n;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						len_q   <= root_n;
						num_c_q <= {abs_c, {FRAC_BITS{1'b0}}};
						num_s_q <= {abs_s, {FRAC_BITS{1'b0}}};
						rem_c_q <= '0;
						rem_s_q <= '0;
						quo_c_q <= '0;
						quo_s_q <= '0;
						neg_c_q <= cos_in[TRIG_W-1];
						neg_s_q <= sin_in[TRIG_W-1];
						cnt_q   <= NU_CNT_W'(NQ_W - 1);
					end
				end
				NU_DIVIDE: begin
					num_c_q <= num_c_q << 1;
					num_s_q <= num_s_q << 1;
					rem_c_q <= ge_c ? dc[ROOT_W-1:0] : tc[ROOT_W-1:0];
					rem_s_q <= ge_s ? ds[ROOT_W-1:0] : ts[ROOT_W-1:0];
					quo_c_q <= {quo_c_q[NQ_W-2:0], ge_c};
					quo_s_q <= {quo_s_q[NQ_W-2:0], ge_s};
					cnt_q   <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: dv/testbench.sv
// testbench: checks ray_oriented_box_slab_test_core with a directed table and random rays
// the box model inside predicts the result word of each ray not given a known result
// depends on robs_pkg, robs_if and ray_oriented_box_slab_test_core from the rtl

module testbench import robs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LIMIT      = 400000;
	localparam int  HOLD_LEN   = 400;
	localparam int  SETTLE     = 60;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(11);

	typedef struct packed {
		logic signed [IN_W-1:0] ox, oy, oz, vx, vy, vz;
		logic [HALF_W-1:0]      md;
	} ray_word_t;

	typedef struct packed {
		logic                     hit;
		logic [HALF_W-1:0]        t;
		logic signed [TRIG_W-1:0] nx, ny, nz;
	} res_word_t;

	typedef struct packed {
		ray_word_t r;
		logic      known;
		res_word_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	robs_ray_if ray ();
	robs_res_if res ();
	robs_cfg_if cfg ();

	ray_oriented_box_slab_test_core u_dut (
		.clk(clk), .arst_n(arst_n), .ray(ray.sink), .res(res.source), .cfg(cfg.sink)
	);

	always #5 clk = ~clk;

	longint    cen_x, cen_y, cen_z, half_x, half_y, half_z, cos_y, sin_y;
	res_word_t hits_due[$];
	row_t      table_rows[$];
	int        errors;
	int        results_seen;
	int        cycles;
	int        burst_left;

	function automatic longint sq_root(longint v);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE) v = ONE;
		if (v < -ONE) v = -ONE;
		return v;
	endfunction

	function automatic res_word_t box_hit(ray_word_t r);
		longint dx, dy, dz, vx, vy, vz, t1, t2, tmp, sg, tmin, tmax, sgmin;
		longint wx, wz, len, nx, ny, nz;
		longint lo [3];
		longint ld [3];
		longint hb [3];
		int ax, amin;
		bit h;
		res_word_t o;
		dx = longint'(r.ox) - cen_x;
		dy = longint'(r.oy) - cen_y;
		dz = longint'(r.oz) - cen_z;
		vx = longint'(r.vx);
		vy = longint'(r.vy);
		vz = longint'(r.vz);
		lo[0] = (dx * cos_y - dz * sin_y) >>> FRAC_BITS;
		lo[1] = dy;
		lo[2] = (dx * sin_y + dz * cos_y) >>> FRAC_BITS;
		ld[0] = (vx * cos_y - vz * sin_y) >>> FRAC_BITS;
		ld[1] = vy;
		ld[2] = (vx * sin_y + vz * cos_y) >>> FRAC_BITS;
		hb[0] = half_x;
		hb[1] = half_y;
		hb[2] = half_z;
		tmin = 0;
		tmax = longint'(r.md);
		sgmin = 1;
		amin = -1;
		h = 1;
		nx = 0;
		ny = 0;
		nz = 0;
		for (ax = 0; ax < 3 && h; ax++) begin
			if (ld[ax] == 0) begin
				if (lo[ax] < -hb[ax] || lo[ax] > hb[ax]) h = 0;
				continue;
			end
			sg = -1;
			t1 = ((-hb[ax] - lo[ax]) * ONE) / ld[ax];
			t2 = ((hb[ax] - lo[ax]) * ONE) / ld[ax];
			if (t1 > 64'sd2147483647) t1 = 64'sd2147483647;
			if (t1 < -64'sd2147483648) t1 = -64'sd2147483648;
			if (t2 > 64'sd2147483647) t2 = 64'sd2147483647;
			if (t2 < -64'sd2147483648) t2 = -64'sd2147483648;
			if (t1 > t2) begin
				tmp = t1;
				t1 = t2;
				t2 = tmp;
				sg = 1;
			end
			if (t1 > tmin) begin
				tmin = t1;
				amin = ax;
				sgmin = sg;
			end
			if (t2 < tmax) tmax = t2;
			if (tmin > tmax) h = 0;
		end
		if (amin < 0) h = 0;
		if (h) begin
			if (amin == 1) begin
				ny = sgmin * ONE;
			end else begin
				len = sq_root(cos_y * cos_y + sin_y * sin_y);
				if (amin == 0) begin
					wx = sgmin * cos_y;
					wz = -sgmin * sin_y;
				end else begin
					wx = sgmin * sin_y;
					wz = sgmin * cos_y;
				end
				if (len != 0) begin
					nx = (wx * ONE) / len;
					nz = (wz * ONE) / len;
				end
			end
			nx = clamp_unit(nx);
			ny = clamp_unit(ny);
			nz = clamp_unit(nz);
		end else begin
			tmin = 0;
		end
		o.hit = h;
		o.t   = tmin[HALF_W-1:0];
		o.nx  = nx[TRIG_W-1:0];
		o.ny  = ny[TRIG_W-1:0];
		o.nz  = nz[TRIG_W-1:0];
		return o;
	endfunction

	function automatic void add_row(ray_word_t r, logic known, res_word_t e);
		row_t row;
		row.r     = r;
		row.known = known;
		row.e     = e;
		table_rows.insert(table_rows.size(), row);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_CENTER_X: cen_x = longint'(signed'(d));
			REG_CENTER_Y: cen_y = longint'(signed'(d));
			REG_CENTER_Z: cen_z = longint'(signed'(d));
			REG_HALF_X:   half_x = longint'(d[HALF_W-1:0]);
			REG_HALF_Y:   half_y = longint'(d[HALF_W-1:0]);
			REG_HALF_Z:   half_z = longint'(d[HALF_W-1:0]);
			REG_COS_YAW:  cos_y = longint'(signed'(d[TRIG_W-1:0]));
			REG_SIN_YAW:  sin_y = longint'(signed'(d[TRIG_W-1:0]));
			default: ;
		endcase
	endtask

	task automatic set_box(longint cx, longint cy, longint cz, longint hx, longint hy,
		longint hz, longint c, longint s);
		put_reg(REG_CENTER_X, cx[31:0]);
		put_reg(REG_CENTER_Y, cy[31:0]);
		put_reg(REG_CENTER_Z, cz[31:0]);
		put_reg(REG_HALF_X, hx[31:0]);
		put_reg(REG_HALF_Y, hy[31:0]);
		put_reg(REG_HALF_Z, hz[31:0]);
		put_reg(REG_COS_YAW, c[31:0]);
		put_reg(REG_SIN_YAW, s[31:0]);
	endtask

	task automatic send_ray(ray_word_t r, bit known, res_word_t want);
		if (burst_left == 0) begin
			ray.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		ray.valid    <= 1'b1;
		ray.origin_x <= r.ox;
		ray.origin_y <= r.oy;
		ray.origin_z <= r.oz;
		ray.dir_x    <= r.vx;
		ray.dir_y    <= r.vy;
		ray.dir_z    <= r.vz;
		ray.max_dist <= r.md;
		@(posedge clk);
		while (!ray.ready) @(posedge clk);
		hits_due.insert(hits_due.size(), known ? want : box_hit(r));
		burst_left--;
	endtask

	task automatic drain;
		ray.valid <= 1'b0;
		burst_left = 0;
		while (hits_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic longint spread(longint n);
		return longint'($urandom_range(0, 2 * n)) - n;
	endfunction

	function automatic ray_word_t random_ray;
		ray_word_t r;
		longint ox, oy, oz;
		if ($urandom_range(0, 4) == 0) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
			return r;
		end
		ox = spread(8 * ONE);
		oy = spread(8 * ONE);
		oz = spread(8 * ONE);
		r.ox = 32'(cen_x + ox);
		r.oy = 32'(cen_y + oy);
		r.oz = 32'(cen_z + oz);
		r.vx = ($urandom_range(0, 7) == 0) ? 32'sd0 : 32'(-ox + spread(ONE));
		r.vy = ($urandom_range(0, 7) == 0) ? 32'sd0 : 32'(-oy + spread(ONE));
		r.vz = ($urandom_range(0, 7) == 0) ? 32'sd0 : 32'(-oz + spread(ONE));
		r.md = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 * ONE));
		return r;
	endfunction

	function automatic ray_word_t mk(longint ox, longint oy, longint oz, longint vx,
		longint vy, longint vz, longint md);
		ray_word_t r;
		r.ox = 32'(ox);
		r.oy = 32'(oy);
		r.oz = 32'(oz);
		r.vx = 32'(vx);
		r.vy = 32'(vy);
		r.vz = 32'(vz);
		r.md = 31'(md);
		return r;
	endfunction

	function automatic res_word_t hit_of(longint t, longint nx, longint ny, longint nz);
		res_word_t o;
		o.hit = (t != 0 || nx != 0 || ny != 0 || nz != 0);
		o.t   = 31'(t);
		o.nx  = 18'(nx);
		o.ny  = 18'(ny);
		o.nz  = 18'(nz);
		return o;
	endfunction

	// receiver: stall patterns plus one long hold-off
	initial begin
		bit held;
		int mode;
		held = 0;
		mode = 0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 40) begin
				held = 1;
				res.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if ((cycles % 64) == 0) mode = $urandom_range(0, 2);
			case (mode)
				0: res.ready <= 1'b1;
				1: res.ready <= ($urandom_range(0, 3) != 0);
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		res_word_t w;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (hits_due.size() == 0) begin
				report("unexpected word", res.hit, 0);
			end else begin
				w = hits_due.pop_front();
				if (res.hit !== w.hit) report("hit", res.hit, w.hit);
				if (res.t_hit !== w.t) report("t_hit", res.t_hit, w.t);
				if (res.normal_x !== w.nx) report("normal_x", res.normal_x, w.nx);
				if (res.normal_y !== w.ny) report("normal_y", res.normal_y, w.ny);
				if (res.normal_z !== w.nz) report("normal_z", res.normal_z, w.nz);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		res_word_t none;
		int i, p;
		none = hit_of(0, 0, 0, 0);
		errors = 0;
		results_seen = 0;
		cycles = 0;
		burst_left = 0;
		cen_x = 0; cen_y = 0; cen_z = 0;
		half_x = ONE; half_y = ONE; half_z = ONE;
		cos_y = ONE; sin_y = 0;
		ray.valid <= 1'b0;
		ray.origin_x <= '0; ray.origin_y <= '0; ray.origin_z <= '0;
		ray.dir_x <= '0; ray.dir_y <= '0; ray.dir_z <= '0;
		ray.max_dist <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;

		add_row(mk(-3*ONE, 0, 0, ONE, 0, 0, 10*ONE), 1'b1, hit_of(2*ONE, -ONE, 0, 0));
		add_row(mk(0, 5*ONE, 0, 0, -ONE, 0, 10*ONE), 1'b1, hit_of(4*ONE, 0, ONE, 0));
		add_row(mk(0, 0, 2*ONE, 0, 0, -2*ONE, 10*ONE), 1'b1, hit_of(ONE/2, 0, 0, ONE));
		// origin inside
		add_row(mk(0, 0, 0, ONE, ONE, ONE, 10*ONE), 1'b1, none);
		// zero direction
		add_row(mk(0, 0, 0, 0, 0, 0, 10*ONE), 1'b1, none);
		// parallel, outside the y slab
		add_row(mk(0, 5*ONE, 0, ONE, 0, 0, 10*ONE), 1'b1, none);
		// box behind the ray
		add_row(mk(3*ONE, 0, 0, ONE, 0, 0, 10*ONE), 1'b1, none);
		// beyond max distance, then exactly at it
		add_row(mk(-3*ONE, 0, 0, ONE, 0, 0, ONE), 1'b1, none);
		add_row(mk(-3*ONE, 0, 0, ONE, 0, 0, 2*ONE), 1'b1, hit_of(2*ONE, -ONE, 0, 0));
		add_row(mk(2147483647, 2147483647, 2147483647, -2147483648,
			-2147483648, -2147483648, 2147483647), 1'b0, none);
		add_row(mk(-2147483648, -2147483648, -2147483648, 2147483647,
			2147483647, 2147483647, 0), 1'b0, none);
		add_row(mk(-3*ONE, 0, 0, 1, 0, 0, 2147483647), 1'b0, none);
		add_row(mk(-ONE, 0, 0, ONE, 0, 0, 0), 1'b0, none);
		add_row(mk(-3*ONE, -3*ONE, 0, ONE, ONE, 0, 10*ONE), 1'b0, none);
		add_row(mk(0, 0, 3*ONE, -1, -1, -1, 2147483647), 1'b0, none);
		add_row(mk(0, 0, 0, 0, -ONE, 0, 2147483647), 1'b1, none);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < table_rows.size(); i++)
			send_ray(table_rows[i].r, table_rows[i].known, table_rows[i].e);

		for (p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: ;
				1: set_box(5*ONE, -2*ONE, 3*ONE, 2*ONE, ONE, 3*ONE, 56756, 32768);
				2: set_box(0, 0, 0, ONE, ONE/2, 4*ONE, 0, ONE);
				3: set_box(2147483647, -2147483648, 2147483647, 0, 2147483647, 0, -ONE, 0);
				4: set_box(0, 0, 0, ONE, ONE, ONE, 0, 0);
				5: set_box(-ONE, ONE, 0, 2147483647, ONE, 2147483647, -ONE, -ONE);
				6: begin
					set_box(spread(16*ONE), spread(16*ONE), spread(16*ONE),
						$urandom_range(0, 4*ONE), $urandom_range(0, 4*ONE),
						$urandom_range(0, 4*ONE), spread(ONE), spread(ONE));
					put_reg(REG_UNUSED, $urandom);
				end
				default: set_box(0, 0, 0, ONE, ONE, ONE, ONE, 0);
			endcase
			cfg.valid <= 1'b0;
			for (i = 0; i < 52; i++) send_ray(random_ray(), 1'b0, none);
		end

		drain();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: ray_oriented_box_slab_test_core.f
rtl/core/robs_pkg.sv
rtl/core/robs_if.sv
rtl/core/robs_div.sv
rtl/core/robs_norm.sv
rtl/core/ray_oriented_box_slab_test_core.sv
dv/testbench.sv
